// File: rtl/ogg_page_header_sync_core_defines.svh
`ifndef OGG_PAGE_HEADER_SYNC_CORE_DEFINES_SVH
`define OGG_PAGE_HEADER_SYNC_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OGG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OGG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ogg_hdr_pkg.sv
package ogg_hdr_pkg;

  // Size of the fixed part of a page header.
  localparam int HEADER_BYTES = 27;
  localparam int FILL_W       = $clog2(HEADER_BYTES + 1);
  localparam int SKIP_W       = 31;

  // "OggS" with the first byte in the low bits.
  localparam logic [31:0] CAPTURE_PATTERN = 32'h5367_674F;

  // Request kinds on the input channel.
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_LIMIT = 2'd1,
    ST_END   = 2'd2
  } status_t;

  // Byte i of the window sits in element i.
  typedef logic [HEADER_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SKIP_W-1:0] bytes_skipped;
    logic [7:0]        stream_version;
    logic [7:0]        header_type;
    logic [63:0]       granule_position;
    logic [31:0]       serial_number;
    logic [31:0]       page_sequence;
    logic [31:0]       page_checksum;
    logic [7:0]        segment_count;
  } out_item_t;

  // Decoded header fields handed from the decoder to the core.
  typedef struct packed {
    logic        hdr_ok;
    logic [7:0]  stream_version;
    logic [7:0]  header_type;
    logic [63:0] granule_position;
    logic [31:0] serial_number;
    logic [31:0] page_sequence;
    logic [31:0] page_checksum;
    logic [7:0]  segment_count;
  } hdr_fields_t;

endpackage

// File: rtl/ogg_hdr_decode.sv
module ogg_hdr_decode (
  input  ogg_hdr_pkg::window_t     window,
  output ogg_hdr_pkg::hdr_fields_t fields
);

  // The window holds a header when the capture pattern leads it and the
  // segment count is not zero.
  assign fields.hdr_ok = (window[3:0] == ogg_hdr_pkg::CAPTURE_PATTERN) &&
                         (window[26] != 8'd0);

  // Multi-byte fields are little endian, so a packed slice reads them directly.
  assign fields.stream_version   = window[4];
  assign fields.header_type      = window[5];
  assign fields.granule_position = window[13:6];
  assign fields.serial_number    = window[17:14];
  assign fields.page_sequence    = window[21:18];
  assign fields.page_checksum    = window[25:22];
  assign fields.segment_count    = window[26];

endmodule

// File: rtl/ogg_page_header_sync_core.sv
// A result is registered in the output register, or in the skid register while the output is held.
// Throughput: one input byte per cycle while the skid register is empty; the window shift and
// header test complete in the accepting cycle, and an output register plus a skid register decouple the two sides.
// Reset clears the fill level, the skip count, the sync limit and both output stages;
// the window bytes are not reset and are only read once the window has been refilled.
`include "ogg_page_header_sync_core_defines.svh"

module ogg_page_header_sync_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ogg_hdr_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ogg_hdr_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ogg_hdr_pkg::SKIP_W-1:0] cfg_data
);

  localparam logic [ogg_hdr_pkg::FILL_W-1:0] FULL =
    ogg_hdr_pkg::FILL_W'(ogg_hdr_pkg::HEADER_BYTES);
  localparam logic [ogg_hdr_pkg::FILL_W-1:0] LAST_FILL =
    ogg_hdr_pkg::FILL_W'(ogg_hdr_pkg::HEADER_BYTES - 1);

  ogg_hdr_pkg::window_t                window;
  ogg_hdr_pkg::window_t                window_next;
  logic [ogg_hdr_pkg::FILL_W-1:0]      fill_level;
  logic [ogg_hdr_pkg::FILL_W-1:0]      fill_level_next;
  logic [ogg_hdr_pkg::SKIP_W-1:0]      skip_count;
  logic [ogg_hdr_pkg::SKIP_W-1:0]      skip_count_next;
  logic [ogg_hdr_pkg::SKIP_W-1:0]      skip_inc;
  logic [ogg_hdr_pkg::SKIP_W-1:0]      sync_limit;
  logic [ogg_hdr_pkg::SKIP_W-1:0]      limit_eff;
  ogg_hdr_pkg::hdr_fields_t            hdr;
  ogg_hdr_pkg::out_item_t              result;
  ogg_hdr_pkg::out_item_t              skid_data;
  logic                                skid_valid;
  logic                                has_result;
  logic                                in_fire;
  logic                                push;
  logic                                pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign push      = in_fire && has_result;

  // Every byte goes in at the top of the window; once full this is the sliding shift.
  assign window_next = {in_data.data_byte, window[ogg_hdr_pkg::HEADER_BYTES-1:1]};

  ogg_hdr_decode u_decode (
    .window (window_next),
    .fields (hdr)
  );

  // A zero limit stands for the largest count.
  assign limit_eff = (sync_limit == '0) ? '1 : sync_limit;
  assign skip_inc  = skip_count + ogg_hdr_pkg::SKIP_W'(1);

  // Decide the outcome of the beat on the input channel.
  always_comb begin
    has_result      = 1'b0;
    fill_level_next = fill_level;
    skip_count_next = skip_count;
    result          = '0;
    result.status   = ogg_hdr_pkg::ST_FOUND;
    if (in_data.req_type == ogg_hdr_pkg::REQ_END) begin
      has_result           = 1'b1;
      result.status        = ogg_hdr_pkg::ST_END;
      result.bytes_skipped = skip_count;
    end else if (fill_level != FULL) begin
      fill_level_next = fill_level + ogg_hdr_pkg::FILL_W'(1);
      if (fill_level == LAST_FILL && hdr.hdr_ok) begin
        has_result = 1'b1;
      end
      result.bytes_skipped = skip_count;
    end else begin
      skip_count_next      = skip_inc;
      result.bytes_skipped = skip_inc;
      if (skip_inc >= limit_eff) begin
        has_result    = 1'b1;
        result.status = ogg_hdr_pkg::ST_LIMIT;
      end else if (hdr.hdr_ok) begin
        has_result = 1'b1;
      end
    end
    // Header fields are carried only when a header was found.
    if (has_result && result.status == ogg_hdr_pkg::ST_FOUND) begin
      result.stream_version   = hdr.stream_version;
      result.header_type      = hdr.header_type;
      result.granule_position = hdr.granule_position;
      result.serial_number    = hdr.serial_number;
      result.page_sequence    = hdr.page_sequence;
      result.page_checksum    = hdr.page_checksum;
      result.segment_count    = hdr.segment_count;
    end
    // Any result restarts the search from an empty window.
    if (has_result) begin
      fill_level_next = '0;
      skip_count_next = '0;
    end
  end

  // Window bytes need no reset.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.req_type == ogg_hdr_pkg::REQ_DATA) begin
      window <= window_next;
    end
  end

  // Search state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      skip_count <= '0;
      sync_limit <= '0;
    end else begin
      if (in_fire) begin
        fill_level <= fill_level_next;
        skip_count <= skip_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        sync_limit <= cfg_data;
      end
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `OGG_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid holds a beat while output is empty")
  `OGG_ASSERT_NOW(a_fill_in_range, 1'b1, fill_level <= FULL, "fill level beyond window size")
  `OGG_ASSERT_NOW(a_skip_only_when_full, skip_count != '0, fill_level == FULL, "bytes counted while filling")
  `OGG_ASSERT_NEXT(a_restart_after_result, push, fill_level == '0 && skip_count == '0, "search not restarted after a result")
  `OGG_ASSERT_NEXT(a_push_lands, push, out_valid, "result lost")

endmodule

// File: tb/ogg_sync_checker.sv
`timescale 1ns / 100ps

// Watches the three channels of the page header synchroniser, predicts the
// results that each input beat causes and compares them with the output beats.
module ogg_sync_checker
  import ogg_hdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SKIP_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  // Private copy of the search state and the limit register.
  window_t           win;
  logic [FILL_W-1:0] fill_lvl;
  logic [SKIP_W-1:0] skip_cnt;
  logic [SKIP_W-1:0] sync_limit;

  // Results still owed by the block, oldest first.
  out_item_t sync_results_q[$];

  function automatic bit page_ok();
    return win[3:0] == CAPTURE_PATTERN && win[HEADER_BYTES-1] != 8'h00;
  endfunction

  // A failed search reports only its status and the count reached.
  function automatic void end_search(status_t code);
    out_item_t r;
    r = '0;
    r.status = code;
    r.bytes_skipped = skip_cnt;
    sync_results_q.push_back(r);
    fill_lvl = '0;
    skip_cnt = '0;
  endfunction

  // A good window is decoded from its little-endian fields.
  function automatic void take_header();
    out_item_t r;
    r.status           = ST_FOUND;
    r.bytes_skipped    = skip_cnt;
    r.stream_version   = win[4];
    r.header_type      = win[5];
    r.granule_position = win[13:6];
    r.serial_number    = win[17:14];
    r.page_sequence    = win[21:18];
    r.page_checksum    = win[25:22];
    r.segment_count    = win[26];
    sync_results_q.push_back(r);
    fill_lvl = '0;
    skip_cnt = '0;
  endfunction

  // Moves the search on by one input beat.
  function automatic void advance_sync(in_item_t it);
    logic [SKIP_W-1:0] lim;
    if (it.req_type == REQ_END) begin
      end_search(ST_END);
      return;
    end
    if (fill_lvl < HEADER_BYTES) begin
      win[fill_lvl] = it.data_byte;
      fill_lvl++;
      if (fill_lvl == HEADER_BYTES && page_ok())
        take_header();
      return;
    end
    win = {it.data_byte, win[HEADER_BYTES-1:1]};
    skip_cnt = skip_cnt + 1'b1;
    lim = (sync_limit == '0) ? '1 : sync_limit;
    if (skip_cnt >= lim)
      end_search(ST_LIMIT);
    else if (page_ok())
      take_header();
  endfunction

  task automatic show_result(string tag, out_item_t r);
    $display("  %s st=%0d skip=%0d ver=%02h typ=%02h gran=%016h ser=%08h seq=%08h crc=%08h seg=%02h",
             tag, r.status, r.bytes_skipped, r.stream_version, r.header_type,
             r.granule_position, r.serial_number, r.page_sequence, r.page_checksum,
             r.segment_count);
  endtask

  // Output beats are matched before input beats of the same edge, as a
  // result never leaves in the cycle of the beat that causes it.
  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (rst) begin
      fill_lvl   = '0;
      skip_cnt   = '0;
      sync_limit = '0;
      sync_results_q.delete();
      errors     = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        sync_limit = cfg_data;

      if (out_valid && out_ready) begin
        if (sync_results_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected sync result at %0t", $realtime);
            show_result("actual  ", out_data);
          end
        end else begin
          want = sync_results_q.pop_front();
          bad = out_data.status !== want.status
             || out_data.bytes_skipped !== want.bytes_skipped
             || out_data.stream_version !== want.stream_version
             || out_data.header_type !== want.header_type
             || out_data.granule_position !== want.granule_position
             || out_data.serial_number !== want.serial_number
             || out_data.page_sequence !== want.page_sequence
             || out_data.page_checksum !== want.page_checksum
             || out_data.segment_count !== want.segment_count;
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("sync result mismatch at %0t", $realtime);
              show_result("expected", want);
              show_result("actual  ", out_data);
            end
          end
        end
      end

      if (in_valid && in_ready)
        advance_sync(in_data);
    end
    pending = sync_results_q.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ogg_hdr_pkg::*;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SKIP_W-1:0] cfg_data;
  int                errors;
  int                pending;

  // Traffic shaping, set only at a falling edge, and the count of beats sent.
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_cycles   = 0;
  int unsigned items_sent    = 0;

  // Per-phase limits and idling patterns for the random part.
  int unsigned phase_limit [8] = '{0, 40, 2147483647, 1, 100, 0, 7, 33};
  int          phase_idle  [4] = '{0, 54, 0, 33};
  int          phase_stall [4] = '{0, 0, 54, 33};

  ogg_page_header_sync_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ogg_sync_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one beat after any random gap and waits for it to be taken.
  task automatic send_item(logic req, logic [7:0] b);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.req_type  = req;
    it.data_byte = b;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_DATA, b);
  endtask

  task automatic send_end();
    send_item(REQ_END, 8'($urandom_range(255)));
  endtask

  // Random lead-in, capture pattern (possibly damaged), body and segment count.
  task automatic send_page(int unsigned lead, bit rand_body, logic [7:0] body,
                           logic [7:0] segs, bit broken);
    logic [31:0] pat;
    int unsigned k;
    pat = CAPTURE_PATTERN;
    if (broken)
      pat[8*$urandom_range(3) +: 8] ^= 8'($urandom_range(1, 255));
    repeat (lead) send_byte(8'($urandom_range(255)));
    for (k = 0; k < 4; k++)
      send_byte(pat[8*k +: 8]);
    for (k = 0; k < 22; k++)
      send_byte(rand_body ? 8'($urandom_range(255)) : body);
    send_byte(segs);
  endtask

  // Mostly well-formed pages with random content, the rest stream ends, noise and damage.
  task automatic random_unit();
    int unsigned pick;
    int unsigned lead;
    logic [7:0]  segs;
    pick = $urandom_range(99);
    lead = ($urandom_range(4) == 0) ? $urandom_range(60) : $urandom_range(3);
    segs = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    if (pick < 8)
      send_end();
    else if (pick < 72)
      send_page(lead, 1'b1, 8'h00, segs, 1'b0);
    else if (pick < 82)
      send_page(lead, 1'b1, 8'h00, segs, 1'b1);
    else
      repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(255)));
  endtask

  // Lets every owed result come out, then gives the pipeline time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [SKIP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          ph;
    int unsigned first;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: stream end when empty and while filling.
    send_end();
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'hFF);
    send_item(REQ_END, 8'hA5);
    // Headers with all body bytes at both extremes.
    send_page(0, 1'b0, 8'hFF, 8'hFF, 1'b0);
    send_page(0, 1'b0, 8'h00, 8'h01, 1'b0);
    // Zero segment count is rejected; one shift, then the stream ends.
    send_page(0, 1'b0, 8'h5A, 8'h00, 1'b0);
    send_byte(8'h00);
    send_end();
    // Header found after three bytes have been skipped.
    send_page(3, 1'b1, 8'h00, 8'h80, 1'b0);

    // Smallest limit: one shift after filling ends the search.
    drain();
    write_limit(31'd1);
    repeat (28) send_byte(8'h00);
    send_page(0, 1'b1, 8'h00, 8'h07, 1'b0);
    send_page(2, 1'b1, 8'h00, 8'h07, 1'b0);
    send_end();

    // Largest limit behaves as no limit here.
    drain();
    write_limit(31'h7FFF_FFFF);
    send_page(5, 1'b1, 8'h00, 8'h33, 1'b0);

    // Random phases with varying limits and idling.
    for (ph = 0; ph < 8; ph++) begin
      drain();
      @(negedge clk);
      send_idle_pct = phase_idle[ph % 4];
      stall_pct     = phase_stall[ph % 4];
      @(posedge clk);
      write_limit(SKIP_W'(phase_limit[ph]));
      first = items_sent;
      while (items_sent - first < 160) random_unit();

      // Back-pressure: the receiver holds off while results keep coming.
      if (ph == 3) begin
        drain();
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 400;
        @(posedge clk);
        repeat (30) send_end();
        repeat (3) send_page(0, 1'b1, 8'h00, 8'($urandom_range(1, 255)), 1'b0);
        repeat (5) send_end();
      end
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ogg_hdr_pkg.sv
rtl/ogg_hdr_decode.sv
rtl/ogg_page_header_sync_core.sv
tb/ogg_sync_checker.sv
tb/tb.sv
